// ----- design/wfrd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfrd_pkg: shared widths, constants and helper functions
// Field widths of the date and day-number datapath, the reciprocal used for
// the constant divide by 25, and the month offset table.
// ----------------------------------------------------------------------------
package wfrd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 3;

    // Internal day count: large enough for any 14-bit year.
    localparam int DN_W    = 23;
    // Output field widths.
    localparam int DNO_W   = 22;
    localparam int DIFF_W  = 23;

    // floor(x / 25) == (x * 1311) >> 15 for every x below 4681.
    localparam int RECIP_25    = 1311;
    localparam int RECIP_SHIFT = 15;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Configuration register indexes.
    localparam logic [1:0] REG_YEAR    = 2'd0;
    localparam logic [1:0] REG_MONTH   = 2'd1;
    localparam logic [1:0] REG_DAY     = 2'd2;
    localparam logic [1:0] REG_WEEKDAY = 2'd3;

    typedef logic [DN_W-1:0] day_count_t;

    // Days in the months before the given one, for a common year.
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            default: r = 9'd334;
        endcase
        return r;
    endfunction

    // Remainder modulo 7 by folding 3-bit groups, since 8 is 1 modulo 7.
    function automatic logic [2:0] mod7(input day_count_t n);
        logic [23:0] padded;
        logic [5:0]  sum1;
        logic [3:0]  sum2;
        logic [3:0]  sum3;
        padded = {1'b0, n};
        sum1 = 6'd0;
        for (int g = 0; g < 8; g++)
        begin
            sum1 = sum1 + 6'(padded[3*g +: 3]);
        end
        sum2 = 4'(sum1[5:3]) + 4'(sum1[2:0]);
        sum3 = 4'(sum2[3]) + 4'(sum2[2:0]);
        if (sum3 >= 4'd7)
        begin
            sum3 = sum3 - 4'd7;
        end
        return sum3[2:0];
    endfunction

endpackage

// ----- design/wfrd_day_count.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfrd_day_count: four-stage Gregorian day number pipeline
// Clamps the date, splits the year into 365*(y-1) and the leap corrections
// through reciprocal multiplies, then sums in two adder stages.
// ----------------------------------------------------------------------------
module wfrd_day_count #(
    parameter int MAX_YEAR = 9999
) (
    input  logic                          clk,
    input  logic [3:0]                    en,
    input  logic [wfrd_pkg::YEAR_W-1:0]   year,
    input  logic [wfrd_pkg::MONTH_W-1:0]  month,
    input  logic [wfrd_pkg::DAY_W-1:0]    day,
    output wfrd_pkg::day_count_t          day_number
);

    localparam logic [15:0] MaxYear16 = 16'(MAX_YEAR);
    localparam logic [22:0] Recip     = 23'(wfrd_pkg::RECIP_25);
    localparam int          QHi       = 22;
    localparam int          QLo       = wfrd_pkg::RECIP_SHIFT;

    // Stage 1
    logic [13:0] y_clip;
    logic [13:0] y1_next;
    logic [22:0] mul_y1_next;
    logic [22:0] mul_y_next;
    logic [wfrd_pkg::MONTH_W-1:0] m_clip;

    logic [13:0] y1_reg;
    logic [22:0] mul_y1_reg;
    logic [22:0] mul_y_reg;
    logic [11:0] yq_reg;
    logic [1:0]  ylow_reg;
    logic [wfrd_pkg::MONTH_W-1:0] m1_reg;
    logic [wfrd_pkg::DAY_W-1:0]   d1_reg;

    always_comb
    begin
        if (year == '0)
        begin
            y_clip = 14'd1;
        end
        else if ({2'b00, year} > MaxYear16)
        begin
            y_clip = MaxYear16[13:0];
        end
        else
        begin
            y_clip = year;
        end
        if (month == '0)
        begin
            m_clip = wfrd_pkg::MONTH_JAN;
        end
        else if (month > wfrd_pkg::MONTH_DEC)
        begin
            m_clip = wfrd_pkg::MONTH_DEC;
        end
        else
        begin
            m_clip = month;
        end
        y1_next     = y_clip - 14'd1;
        mul_y1_next = {11'd0, y1_next[13:2]} * Recip;
        mul_y_next  = {11'd0, y_clip[13:2]} * Recip;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            y1_reg     <= y1_next;
            mul_y1_reg <= mul_y1_next;
            mul_y_reg  <= mul_y_next;
            yq_reg     <= y_clip[13:2];
            ylow_reg   <= y_clip[1:0];
            m1_reg     <= m_clip;
            d1_reg     <= day;
        end
    end

    // Stage 2: quotients by 100, leap test, 365*(y-1), month offset.
    logic [7:0]  q100_next;
    logic [7:0]  cent;
    logic [12:0] cent25;
    logic        leap;
    logic [22:0] y365_next;

    logic [22:0] y365_reg;
    logic [11:0] q4_reg;
    logic [7:0]  q100_reg;
    logic        leap_add_reg;
    logic [8:0]  dbm_reg;
    logic [wfrd_pkg::DAY_W-1:0] d2_reg;

    always_comb
    begin
        q100_next = mul_y1_reg[QHi:QLo];
        cent      = mul_y_reg[QHi:QLo];
        cent25    = 13'({cent, 4'b0000}) + 13'({cent, 3'b000}) + 13'(cent);
        // Leap: divisible by 4, and either not a century or a century divisible by 4.
        leap      = (ylow_reg == 2'd0) &&
                    (({1'b0, yq_reg} != cent25) || (cent[1:0] == 2'd0));
        y365_next = {9'd0, y1_reg} * 23'd365;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            y365_reg     <= y365_next;
            q4_reg       <= y1_reg[13:2];
            q100_reg     <= q100_next;
            leap_add_reg <= leap && (m1_reg > wfrd_pkg::MONTH_FEB);
            dbm_reg      <= wfrd_pkg::days_before(m1_reg);
            d2_reg       <= d1_reg;
        end
    end

    // Stage 3: year part and month/day part summed separately.
    logic [22:0] yr_part_reg;
    logic [8:0]  md_part_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            yr_part_reg <= y365_reg + 23'(q4_reg) - 23'(q100_reg) + 23'(q100_reg[7:2]);
            md_part_reg <= dbm_reg + 9'(leap_add_reg) + 9'(d2_reg);
        end
    end

    // Stage 4: final day number.
    wfrd_pkg::day_count_t dn_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            dn_reg <= yr_part_reg + 23'(md_part_reg);
        end
    end

    assign day_number = dn_reg;

endmodule

// ----- design/wfrd_result.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfrd_result: difference and weekday stages
// Forms the signed day difference and both day numbers modulo 7, then the
// weekday in the output register.
// ----------------------------------------------------------------------------
module wfrd_result (
    input  logic                              clk,
    input  logic [1:0]                        en,
    input  wfrd_pkg::day_count_t              target_dn,
    input  wfrd_pkg::day_count_t              known_dn,
    input  logic [wfrd_pkg::WDAY_W-1:0]       ref_weekday,
    output logic [wfrd_pkg::DNO_W-1:0]        day_number,
    output logic [wfrd_pkg::DIFF_W-1:0]       day_difference,
    output logic [wfrd_pkg::WDAY_W-1:0]       weekday
);

    // Stage 5
    wfrd_pkg::day_count_t dn_reg;
    logic [23:0]          diff_reg;
    logic [2:0]           t7_reg;
    logic [2:0]           k7_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dn_reg   <= target_dn;
            diff_reg <= {1'b0, target_dn} - {1'b0, known_dn};
            t7_reg   <= wfrd_pkg::mod7(target_dn);
            k7_reg   <= wfrd_pkg::mod7(known_dn);
        end
    end

    // Stage 6: (ref_weekday + target - known) mod 7, kept non-negative by adding 7.
    logic [4:0] wsum;
    logic [2:0] wd_next;

    always_comb
    begin
        wsum = 5'(ref_weekday) + 5'(t7_reg) + 5'd7 - 5'(k7_reg);
        if (wsum >= 5'd14)
        begin
            wsum = wsum - 5'd14;
        end
        else if (wsum >= 5'd7)
        begin
            wsum = wsum - 5'd7;
        end
        wd_next = wsum[2:0];
    end

    logic [wfrd_pkg::DNO_W-1:0]  dno_reg;
    logic [wfrd_pkg::DIFF_W-1:0] diff_out_reg;
    logic [wfrd_pkg::WDAY_W-1:0] wd_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            dno_reg      <= dn_reg[wfrd_pkg::DNO_W-1:0];
            diff_out_reg <= diff_reg[wfrd_pkg::DIFF_W-1:0];
            wd_reg       <= wd_next;
        end
    end

    assign day_number     = dno_reg;
    assign day_difference = diff_out_reg;
    assign weekday        = wd_reg;

endmodule

// ----- design/weekday_from_reference_date.sv -----
`timescale 1ns / 1ps
// An accepted request passes the day-count stages, then the result stages, to the output.
// Throughput: one date per cycle while results are taken; six register stages.
// A stalled output backs the pipeline up stage by stage, so bubbles are squeezed out.
// Reset clears all stage valid bits and loads the reference registers with 2000-01-01,
// weekday Saturday; after reset or a write the reference day number settles in its own pipe.
// ----------------------------------------------------------------------------
// weekday_from_reference_date: Gregorian day number, difference and weekday
// Computes the day number of a date counted from 1 January of year 1, its
// signed distance to a configurable reference date, and its weekday.
// ----------------------------------------------------------------------------
module weekday_from_reference_date #(
    parameter int MAX_YEAR = 9999
) (
    input  logic        clk,
    input  logic        rst_n,

    // Input requests.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // year [13:0], month [17:14], day [22:18], zero [23]

    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // day_number [21:0], day_difference [44:22], weekday [47:45]

    // Configuration writes.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_wdata
);

    localparam int Stages = 6;

    // ------------------------------------------------------------------
    // Reference date registers. Software must write these only while no request is in
    // flight; the block itself does not enforce it, and every stage reads them directly.
    // ------------------------------------------------------------------
    logic [wfrd_pkg::YEAR_W-1:0]  ref_year_reg;
    logic [wfrd_pkg::MONTH_W-1:0] ref_month_reg;
    logic [wfrd_pkg::DAY_W-1:0]   ref_day_reg;
    logic [wfrd_pkg::WDAY_W-1:0]  ref_weekday_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_year_reg    <= 14'd2000;
            ref_month_reg   <= 4'd1;
            ref_day_reg     <= 5'd1;
            ref_weekday_reg <= 3'd6;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                wfrd_pkg::REG_YEAR:    ref_year_reg    <= cfg_wdata[13:0];
                wfrd_pkg::REG_MONTH:   ref_month_reg   <= cfg_wdata[3:0];
                wfrd_pkg::REG_DAY:     ref_day_reg     <= cfg_wdata[4:0];
                wfrd_pkg::REG_WEEKDAY: ref_weekday_reg <= cfg_wdata[2:0];
                default:               ref_year_reg    <= ref_year_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage control. Each stage loads when it is empty or when the stage
    // after it loads; the last stage is the output register.
    // ------------------------------------------------------------------
    logic [Stages-1:0] valid_reg;
    logic [Stages-1:0] valid_next;
    logic [Stages-1:0] en;

    always_comb
    begin
        en[Stages-1] = !valid_reg[Stages-1] || m_tready;
        for (int i = Stages - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next[0] = en[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < Stages; i++)
        begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[Stages-1];

    // ------------------------------------------------------------------
    // Target day number follows the request through stages 1 to 4. The
    // reference day number runs through its own copy of the same pipe,
    // always enabled, so it follows every register write stage by stage; a
    // request accepted right after a write meets the new value at stage 5.
    // ------------------------------------------------------------------
    wfrd_pkg::day_count_t target_dn;
    wfrd_pkg::day_count_t known_dn;

    wfrd_day_count #(
        .MAX_YEAR (MAX_YEAR)
    ) u_target_count (
        .clk        (clk),
        .en         (en[3:0]),
        .year       (s_tdata[13:0]),
        .month      (s_tdata[17:14]),
        .day        (s_tdata[22:18]),
        .day_number (target_dn)
    );

    wfrd_day_count #(
        .MAX_YEAR (MAX_YEAR)
    ) u_known_count (
        .clk        (clk),
        .en         (4'b1111),
        .year       (ref_year_reg),
        .month      (ref_month_reg),
        .day        (ref_day_reg),
        .day_number (known_dn)
    );

    // Stages 5 and 6: difference, modulo-7 reduction and the output register.
    logic [wfrd_pkg::DNO_W-1:0]  out_day_number;
    logic [wfrd_pkg::DIFF_W-1:0] out_difference;
    logic [wfrd_pkg::WDAY_W-1:0] out_weekday;

    wfrd_result u_result (
        .clk            (clk),
        .en             (en[5:4]),
        .target_dn      (target_dn),
        .known_dn       (known_dn),
        .ref_weekday    (ref_weekday_reg),
        .day_number     (out_day_number),
        .day_difference (out_difference),
        .weekday        (out_weekday)
    );

    assign m_tdata = {out_weekday, out_difference, out_day_number};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Requests are refused only when every stage holds an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (valid_reg == {Stages{1'b1}}))
    else $error("input refused while the pipeline has an empty stage");

    // Items in flight change only by accepted requests and delivered results.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |->
        ($countones(valid_reg) == $countones($past(valid_reg))
            + $past(s_tvalid && s_tready) - $past(m_tvalid && m_tready)))
    else $error("pipeline occupancy lost or duplicated an item");

    // The weekday is always reduced into Sunday to Saturday.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[47:45] != 3'd7))
    else $error("weekday out of range");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for weekday_from_reference_date
// Dates are streamed in through the request channel. Each accepted request is
// run through a local day-count calculation, using a local copy of the
// reference registers. Results are checked field by field, in order. The run
// goes through several reference settings, including out-of-range ones. It
// also includes random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module testbench;

    localparam int YEAR_W  = wfrd_pkg::YEAR_W;
    localparam int MONTH_W = wfrd_pkg::MONTH_W;
    localparam int DAY_W   = wfrd_pkg::DAY_W;
    localparam int WDAY_W  = wfrd_pkg::WDAY_W;
    localparam int DNO_W   = wfrd_pkg::DNO_W;
    localparam int DIFF_W  = wfrd_pkg::DIFF_W;

    localparam int MAX_YEAR     = 9999;
    localparam int RANDOM_DATES = 150;     // random dates per reference setting
    localparam int DRAIN_CYCLES = 12;      // pipeline drain plus margin
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AT      = 320;     // request count that starts the long stall
    localparam int HOLD_CYCLES  = 250;

    // Register map of the configuration port.
    typedef enum logic [1:0] {
        REG_REF_YEAR    = wfrd_pkg::REG_YEAR,
        REG_REF_MONTH   = wfrd_pkg::REG_MONTH,
        REG_REF_DAY     = wfrd_pkg::REG_DAY,
        REG_REF_WEEKDAY = wfrd_pkg::REG_WEEKDAY
    } ref_reg_e;

    // Request fields, highest bits first, as they sit in s_tdata.
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_t;

    // Result fields, highest bits first, as they sit in m_tdata.
    typedef struct packed {
        logic [WDAY_W-1:0] weekday;
        logic [DIFF_W-1:0] day_difference;
        logic [DNO_W-1:0]  day_number;
    } day_result_t;

    // Local copy of the reference registers.
    typedef struct {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WDAY_W-1:0]  weekday;
    } ref_date_t;

    // Days in the months before each month, for a common year.
    localparam int unsigned MONTH_OFFSET [12] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;      // year [13:0], month [17:14], day [22:18], zero [23]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // day_number [21:0], day_difference [44:22], weekday [47:45]
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [13:0] cfg_wdata = '0;

    date_t       date_queue [$];    // dates waiting to be offered
    day_result_t result_queue [$];  // predicted results not yet seen
    ref_date_t   ref_cfg;

    int          error_count = 0;
    int          requests_sent = 0;
    int          results_seen = 0;
    int          cycle_count = 0;
    int          setting_count = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    weekday_from_reference_date #(
        .MAX_YEAR (MAX_YEAR)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Day number of a date, 1 January of year 1 being day 1. The year and the
    // month are clamped into range; the day is added as given, so a day past
    // the end of the month simply runs into the next month.
    function automatic int unsigned day_count_of(input logic [YEAR_W-1:0] y_in,
                                                 input logic [MONTH_W-1:0] m_in,
                                                 input logic [DAY_W-1:0] d_in);
        int unsigned y;
        int unsigned m;
        int unsigned y1;
        int unsigned n;
        y = y_in;
        m = m_in;
        if (y < 1)
        begin
            y = 1;
        end
        if (y > MAX_YEAR)
        begin
            y = MAX_YEAR;
        end
        if (m < 1)
        begin
            m = 1;
        end
        if (m > 12)
        begin
            m = 12;
        end
        y1 = y - 1;
        n = 365 * y1 + y1 / 4 - y1 / 100 + y1 / 400 + MONTH_OFFSET[m - 1];
        // The leap day only counts once February is over.
        if (m > 2 && (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0))
        begin
            n = n + 1;
        end
        return n + d_in;
    endfunction

    // Expected result for one date under the current reference setting. The
    // weekday comes from the full-width difference, reduced into 0..6; a
    // weekday register of 7 therefore behaves like 0.
    function automatic day_result_t predict_day_result(input date_t dt);
        day_result_t r;
        longint      target;
        longint      known;
        longint      diff;
        longint      wd;
        target = day_count_of(dt.year, dt.month, dt.day);
        known  = day_count_of(ref_cfg.year, ref_cfg.month, ref_cfg.day);
        diff   = target - known;
        wd     = (longint'(ref_cfg.weekday) + diff) % 7;
        if (wd < 0)
        begin
            wd = wd + 7;
        end
        r.day_number     = target[DNO_W-1:0];
        r.day_difference = diff[DIFF_W-1:0];
        r.weekday        = wd[WDAY_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        error_count++;
    endtask

    // Random target date. Most dates are well formed; some sit on century
    // and leap-year boundaries, and some use the full bit range of every field
    // so that the clamping of year and month gets exercised.
    function automatic date_t random_date();
        date_t dt;
        int    pick;
        int    edge_years [15] = '{1, 2, 3, 4, 99, 100, 101, 399, 400, 401,
                                   1600, 1900, 2000, 9998, 9999};
        int    edge_days [5] = '{1, 28, 29, 30, 31};
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            dt.year  = YEAR_W'($urandom_range(16383));
            dt.month = MONTH_W'($urandom_range(15));
            dt.day   = DAY_W'($urandom_range(31));
        end
        else if (pick < 25)
        begin
            dt.year  = YEAR_W'(edge_years[$urandom_range(14)]);
            dt.month = MONTH_W'($urandom_range(1, 12));
            dt.day   = DAY_W'(edge_days[$urandom_range(4)]);
        end
        else
        begin
            dt.year  = YEAR_W'($urandom_range(1, MAX_YEAR));
            dt.month = MONTH_W'($urandom_range(1, 12));
            dt.day   = DAY_W'($urandom_range(1, 31));
        end
        return dt;
    endfunction

    function automatic date_t make_date(input int y, input int m, input int d);
        date_t dt;
        dt.year  = YEAR_W'(y);
        dt.month = MONTH_W'(m);
        dt.day   = DAY_W'(d);
        return dt;
    endfunction

    // One register write. The local copy is updated at once, which is safe
    // because writes only happen while nothing is in flight.
    task automatic write_reg(input ref_reg_e idx, input logic [13:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_REF_YEAR:    ref_cfg.year    = value[YEAR_W-1:0];
            REG_REF_MONTH:   ref_cfg.month   = value[MONTH_W-1:0];
            REG_REF_DAY:     ref_cfg.day     = value[DAY_W-1:0];
            REG_REF_WEEKDAY: ref_cfg.weekday = value[WDAY_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Writes a whole reference date, then lets the reference day number settle.
    task automatic set_reference(input logic [13:0] y, input logic [13:0] m,
                                 input logic [13:0] d, input logic [13:0] wd);
        write_reg(REG_REF_YEAR, y);
        write_reg(REG_REF_MONTH, m);
        write_reg(REG_REF_DAY, d);
        write_reg(REG_REF_WEEKDAY, wd);
        setting_count++;
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Waits until every queued date has been taken and every result checked,
    // then gives the pipeline its latency before the next register write.
    task automatic wait_until_idle();
        while (date_queue.size() != 0 || s_tvalid || result_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random_dates(input int count);
        for (int i = 0; i < count; i++)
        begin
            date_queue.push_back(random_date());
        end
    endtask

    // Request driver. A new date is put up whenever the channel is free or
    // the current one is being taken, except on random idle cycles. Idling is
    // switched off for a stretch of requests in the middle of the run.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                result_queue.push_back(predict_day_result(date_t'(s_tdata[22:0])));
                requests_sent <= requests_sent + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (date_queue.size() != 0 &&
                    !((requests_sent < 600 || requests_sent >= 900) &&
                      $urandom_range(99) < 10))
                begin
                    s_tdata  <= {1'b0, date_queue.pop_front()};
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver. Besides the random idle cycles it holds off once for a
    // long stretch while requests keep coming, so that the pipeline fills up
    // and the block has to push back on its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && requests_sent >= HOLD_AT)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if ((results_seen < 600 || results_seen >= 900) && $urandom_range(99) < 10)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Result checker: every result taken is compared with the oldest prediction.
    always @(posedge clk)
    begin
        day_result_t got;
        day_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = day_result_t'(m_tdata);
            results_seen <= results_seen + 1;
            if (result_queue.size() == 0)
            begin
                report_mismatch($sformatf("result %h with no request outstanding", m_tdata));
            end
            else
            begin
                want = result_queue.pop_front();
                if (got.day_number !== want.day_number)
                begin
                    report_mismatch($sformatf("day_number %0d, expected %0d",
                                              got.day_number, want.day_number));
                end
                if (got.day_difference !== want.day_difference)
                begin
                    report_mismatch($sformatf("day_difference %0d, expected %0d",
                                              $signed(got.day_difference),
                                              $signed(want.day_difference)));
                end
                if (got.weekday !== want.weekday)
                begin
                    report_mismatch($sformatf("weekday %0d, expected %0d",
                                              got.weekday, want.weekday));
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, result_queue.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        // Local copy of the reset values: 2000-01-01, a Saturday.
        ref_cfg.year    = 14'd2000;
        ref_cfg.month   = 4'd1;
        ref_cfg.day     = 5'd1;
        ref_cfg.weekday = 3'd6;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);

        // Directed dates under the reset reference.
        date_queue.push_back(make_date(2000, 1, 1));     // the reference itself
        date_queue.push_back(make_date(1, 1, 1));        // earliest date
        date_queue.push_back(make_date(9999, 12, 31));   // latest date
        date_queue.push_back(make_date(0, 1, 1));        // year zero is taken as one
        date_queue.push_back(make_date(16383, 12, 31));  // year beyond the maximum
        date_queue.push_back(make_date(2024, 0, 15));    // month zero
        date_queue.push_back(make_date(2024, 15, 15));   // month beyond December
        date_queue.push_back(make_date(2023, 3, 0));     // day zero
        date_queue.push_back(make_date(2023, 2, 31));    // day past the month's end
        date_queue.push_back(make_date(2000, 2, 29));
        date_queue.push_back(make_date(2000, 3, 1));     // leap by the 400 rule
        date_queue.push_back(make_date(1900, 3, 1));     // century, not leap
        date_queue.push_back(make_date(2100, 3, 1));
        date_queue.push_back(make_date(2004, 3, 1));
        date_queue.push_back(make_date(1999, 12, 31));
        date_queue.push_back(make_date(400, 12, 31));
        date_queue.push_back(make_date(401, 1, 1));
        date_queue.push_back(make_date(1, 12, 31));
        date_queue.push_back(make_date(10922, 10, 21));  // alternating bit patterns
        date_queue.push_back(make_date(5461, 5, 10));
        date_queue.push_back(make_date(9999, 1, 1));
        date_queue.push_back(make_date(8191, 7, 31));
        queue_random_dates(150);
        wait_until_idle();

        // Extreme reference settings, then random ones.
        set_reference(14'd1, 14'd1, 14'd1, 14'd1);
        queue_random_dates(RANDOM_DATES);
        wait_until_idle();

        set_reference(14'd9999, 14'd12, 14'd31, 14'd0);
        queue_random_dates(RANDOM_DATES);
        wait_until_idle();

        // Out-of-range reference: clamped year and month, weekday of 7.
        set_reference(14'd16383, 14'd15, 14'd31, 14'd7);
        queue_random_dates(RANDOM_DATES);
        wait_until_idle();

        set_reference(14'd0, 14'd0, 14'd0, 14'd3);
        queue_random_dates(RANDOM_DATES);
        wait_until_idle();

        // Random settings; the bits above the month, day and weekday register widths
        // are junk that the block has to drop.
        for (int p = 0; p < 3; p++)
        begin
            set_reference(14'($urandom_range(1, MAX_YEAR)),
                          {10'($urandom), 4'($urandom_range(1, 12))},
                          {9'($urandom), 5'($urandom_range(1, 31))},
                          {11'($urandom), 3'($urandom_range(0, 6))});
            queue_random_dates(RANDOM_DATES);
            wait_until_idle();
        end

        if (result_queue.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", result_queue.size()));
        end

        $display("Checked %0d results from %0d requests across %0d reference settings.",
                 results_seen, requests_sent, setting_count + 1);
        $display("Run included clamped fields, leap boundaries and a long output stall.");
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
